@@ hdl/tfir_pkg.sv @@
// Package for the transposed-form FIR filter: widths, operation codes,
// stream packing constants and the per-tap control struct.
// No dependencies.
`default_nettype none

package tfir_pkg;

    localparam int TAPS          = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 16;
    localparam int ACC_BITS      = 40;
    localparam int RND_BITS      = ACC_BITS + 1;
    localparam int TAP_IDX_BITS  = 5;
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;

    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + TAP_IDX_BITS + COEF_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    typedef struct packed {
        logic shift_en;
        logic coef_we;
    } tap_ctl_t;

endpackage

`default_nettype wire

@@ hdl/tfir_tap.sv @@
// One tap of the transposed FIR: coefficient register, multiplier and
// partial-sum register. Depends on tfir_pkg.
`default_nettype none

module tfir_tap
    import tfir_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tap_ctl_t                      ctl,
    input  wire logic signed [COEF_BITS-1:0]   coef_data,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic signed [ACC_BITS-1:0]    sum_in,
    output logic signed [ACC_BITS-1:0]         sum_out
);

    logic signed [COEF_BITS-1:0] coef_reg;
    logic signed [ACC_BITS-1:0]  sum_reg;
    logic signed [PROD_BITS-1:0] prod;

    assign prod    = sample * coef_reg;
    assign sum_out = sum_reg + ACC_BITS'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            sum_reg  <= '0;
        end else begin
            if (ctl.coef_we) begin
                coef_reg <= coef_data;
            end
            if (ctl.shift_en) begin
                sum_reg <= sum_in;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tfir_round.sv @@
// Output stage: rounds the front partial sum to the sample format,
// saturates it and holds the result transaction. Depends on tfir_pkg.
`default_nettype none

module tfir_round
    import tfir_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        acc_valid,
    input  wire logic signed [ACC_BITS-1:0]  acc,
    output logic                             acc_ready,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [OUT_TDATA_BITS-1:0]        m_tdata,   // filtered
    output logic                             m_tuser    // clipped
);

    localparam logic signed [RND_BITS-1:0] SAT_HI = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RND_BITS-1:0] SAT_LO = -SAT_HI - RND_BITS'(1);
    localparam logic signed [RND_BITS-1:0] HALF   = RND_BITS'(1) << (COEF_BITS - 2);

    logic signed [RND_BITS-1:0] rnd_sum;
    logic signed [RND_BITS-1:0] shifted;
    logic [SAMPLE_BITS-1:0]     sat_next;
    logic                       clip_next;
    logic                       out_v_reg;
    logic [SAMPLE_BITS-1:0]     out_data_reg;
    logic                       out_clip_reg;

    assign rnd_sum = RND_BITS'(acc) + HALF;
    assign shifted = rnd_sum >>> (COEF_BITS - 1);

    always_comb begin
        if (shifted > SAT_HI) begin
            sat_next  = SAT_HI[SAMPLE_BITS-1:0];
            clip_next = 1'b1;
        end else if (shifted < SAT_LO) begin
            sat_next  = SAT_LO[SAMPLE_BITS-1:0];
            clip_next = 1'b1;
        end else begin
            sat_next  = shifted[SAMPLE_BITS-1:0];
            clip_next = 1'b0;
        end
    end

    assign acc_ready = !out_v_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (acc_ready) begin
            out_v_reg <= acc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_ready && acc_valid) begin
            out_data_reg <= sat_next;
            out_clip_reg <= clip_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_TDATA_BITS'(out_data_reg);
    assign m_tuser  = out_clip_reg;

endmodule

`default_nettype wire

@@ hdl/transposed_fir_filter.sv @@
// Top level of the transposed-form FIR filter: input register, tap row,
// front-sum register and output stage. Depends on tfir_pkg, tfir_tap, tfir_round.
//
// Usage:
//   s_ channel carries one transaction per item. s_tuser selects the operation:
//   0 filters the sample in s_tdata, 1 writes s_tdata's tap value at tap_index.
//   A filter transaction yields exactly one m_ transaction: the Q1.15 output
//   in m_tdata, rounded half up and saturated, with m_tuser high when it clipped.
//   A coefficient write yields nothing and affects only later samples.
// Path: a sample passes the input register, the front-sum register and the output
//   register in that order before its result is valid at m_tvalid.
// Throughput: one transaction per cycle on both sides while m_tready stays high;
//   every tap multiplies and accumulates in parallel in its own lane on each sample.
// Reset: aresetn low clears all coefficients, all tap partial sums and all
//   pipeline valid flags; the block accepts transactions on the next cycle.
// Stall: while m_tready is low the result is held; the stages behind it fill
//   and s_tready drops only once the input register is occupied and blocked.
`default_nettype none

module transposed_fir_filter
    import tfir_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,   // sample, tap_index, tap_value, pad
    input  wire logic                      s_tuser,   // op
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0]      m_tdata,   // filtered
    output logic                           m_tuser    // clipped
);

    logic                          in_v_reg;
    op_t                           in_op_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TAP_IDX_BITS-1:0]       in_idx_reg;
    logic signed [COEF_BITS-1:0]   in_val_reg;

    logic                          mid_v_reg;
    logic signed [ACC_BITS-1:0]    mid_acc_reg;
    logic                          mid_ready;
    logic                          out_ready;
    logic                          in_fire;
    logic                          shift_en;

    logic signed [ACC_BITS-1:0]    lane_sum [TAPS+1];

    assign mid_ready = !mid_v_reg || out_ready;
    assign in_fire   = in_v_reg && mid_ready;
    assign shift_en  = in_fire && (in_op_reg == OP_FILTER);
    assign s_tready  = !in_v_reg || mid_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg     <= op_t'(s_tuser);
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_idx_reg    <= s_tdata[SAMPLE_BITS +: TAP_IDX_BITS];
            in_val_reg    <= s_tdata[SAMPLE_BITS + TAP_IDX_BITS +: COEF_BITS];
        end
    end

    assign lane_sum[TAPS] = '0;

    for (genvar i = 0; i < TAPS; i++) begin : g_tap
        tap_ctl_t ctl;

        // {shift_en, coef_we}
        assign ctl = {shift_en,
                      in_fire && (in_op_reg == OP_COEF) && (32'(in_idx_reg) == i)};

        tfir_tap u_tap (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .coef_data (in_val_reg),
            .sample    (in_sample_reg),
            .sum_in    (lane_sum[i+1]),
            .sum_out   (lane_sum[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_v_reg <= 1'b0;
        end else if (mid_ready) begin
            mid_v_reg <= in_v_reg && (in_op_reg == OP_FILTER);
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            mid_acc_reg <= lane_sum[0];
        end
    end

    tfir_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_valid (mid_v_reg),
        .acc       (mid_acc_reg),
        .acc_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_coef_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (in_op_reg == OP_COEF) |=> !mid_v_reg)
        else $error("coefficient write produced a result");

    a_filter_to_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_en |=> mid_v_reg)
        else $error("filter transaction lost before output stage");

    a_clip_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[SAMPLE_BITS-1:0] == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
            (m_tdata[SAMPLE_BITS-1:0] == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("clipped result is not a saturation limit");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !mid_v_reg && !in_v_reg)
        else $error("pipeline valid after reset");

endmodule

`default_nettype wire

@@ bench/transposed_fir_filter_tb.sv @@
// Testbench for the transposed-form FIR filter: drives sample and tap-write
// transactions with random gaps and stalls and checks every result against a predictor.
// Depends on tfir_pkg and transposed_fir_filter.
`timescale 1ns / 100ps

module transposed_fir_filter_tb;
    import tfir_pkg::*;

    localparam int     RANDOM_ITEMS  = 1650;
    localparam int     HOLD_AT_ITEM  = 600;
    localparam int     DRAIN_AT_ITEM = 1100;
    localparam int     LONG_HOLD     = 400;
    localparam int     IDLE_LIMIT    = 4000;
    localparam longint OUT_MAX       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN       = -(longint'(1) <<< (SAMPLE_BITS - 1));

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered;
        logic                   clipped;
    } fir_result_t;

    class tfir_scoreboard;
        logic signed [COEF_BITS-1:0] taps [TAPS];
        logic signed [ACC_BITS-1:0]  sums [TAPS];
        fir_result_t                 expected_outputs [$];
        int                          errors;

        function new();
            foreach (taps[i]) begin
                taps[i] = '0;
                sums[i] = '0;
            end
            errors = 0;
        endfunction

        function fir_result_t filter_sample(logic signed [SAMPLE_BITS-1:0] smp);
            longint      front;
            fir_result_t res;
            for (int i = 0; i < TAPS; i++)
                sums[i] = ACC_BITS'(sums[i] + longint'(smp) * longint'(taps[i]));
            // Q10.30 to Q1.15, round half up
            front = (longint'(sums[0]) + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
            res.clipped = 1'b1;
            if (front > OUT_MAX) begin
                res.filtered = SAMPLE_BITS'(OUT_MAX);
            end else if (front < OUT_MIN) begin
                res.filtered = SAMPLE_BITS'(OUT_MIN);
            end else begin
                res.filtered = SAMPLE_BITS'(front);
                res.clipped  = 1'b0;
            end
            for (int i = 0; i < TAPS - 1; i++)
                sums[i] = sums[i+1];
            sums[TAPS-1] = '0;
            return res;
        endfunction

        function void note_input(op_t op, logic signed [SAMPLE_BITS-1:0] smp,
                                 logic [TAP_IDX_BITS-1:0] idx,
                                 logic signed [COEF_BITS-1:0] val);
            if (op == OP_COEF) begin
                if (idx < TAPS)
                    taps[idx] = val;
            end else begin
                expected_outputs = {expected_outputs, filter_sample(smp)};
            end
        endfunction

        function void check_output(logic [SAMPLE_BITS-1:0] filtered, logic clipped);
            fir_result_t want;
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual filtered %h clipped %b",
                         $time, filtered, clipped);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            if (filtered !== want.filtered) begin
                $display("%0t: filtered mismatch: expected %h actual %h",
                         $time, want.filtered, filtered);
                errors++;
            end
            if (clipped !== want.clipped) begin
                $display("%0t: clipped mismatch: expected %b actual %b",
                         $time, want.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_BITS-1:0]   s_tdata;   // sample, tap_index, tap_value, pad
    logic                       s_tuser;   // op
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_BITS-1:0]  m_tdata;   // filtered
    logic                       m_tuser;   // clipped

    tfir_scoreboard sb = new();
    int             items_sent = 0;
    int             idle_cycles = 0;
    bit             gapless = 0;

    transposed_fir_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // 0 full range, 1 small magnitude, 2 corner values
    function automatic logic signed [15:0] pick_value(int mode);
        logic signed [15:0] v;
        v = 16'($urandom);
        case (mode)
            1: v = v >>> $urandom_range(4, 14);
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = -16'sd1;
                    3: v = 16'sd1;
                    default: v = '0;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(op_t op, logic signed [SAMPLE_BITS-1:0] smp,
                             logic [TAP_IDX_BITS-1:0] idx, logic signed [COEF_BITS-1:0] val);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_BITS'({val, idx, smp});
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, smp, idx, val);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // unused fields carry random bits
    task automatic filter(logic signed [SAMPLE_BITS-1:0] smp);
        send_item(OP_FILTER, smp, TAP_IDX_BITS'($urandom), COEF_BITS'($urandom));
    endtask

    task automatic write_tap(logic [TAP_IDX_BITS-1:0] idx, logic signed [COEF_BITS-1:0] val);
        send_item(OP_COEF, SAMPLE_BITS'($urandom), idx, val);
    endtask

    task automatic drain_outputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_output(m_tdata[SAMPLE_BITS-1:0], m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("transposed_fir_filter regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side backpressure
    initial begin : receiver
        int  burst;
        int  stall;
        int  r;
        bit  held;
        held     = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && items_sent >= HOLD_AT_ITEM) begin
                held = 1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else begin
                burst = $urandom_range(1, 40);
                @(negedge aclk);
                m_tready <= 1'b1;
                repeat (burst - 1) @(negedge aclk);
                r = $urandom_range(0, 99);
                if (r < 30)
                    stall = 0;
                else if (r < 85)
                    stall = $urandom_range(1, 3);
                else if (r < 97)
                    stall = $urandom_range(4, 12);
                else
                    stall = $urandom_range(20, 80);
                if (stall > 0) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int  k;
        int  run;
        int  cmode;
        int  smode;
        bit  drained;
        drained  = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_FILTER;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero taps, clipping both ways, half-up rounding
        filter(16'sh7fff);
        write_tap(5'd0, 16'sh8000);
        write_tap(5'd1, 16'sh7fff);
        write_tap(5'd31, 16'sh7fff);
        filter(16'sh8000);
        filter(16'sh7fff);
        filter(16'sd0);
        write_tap(5'd1, 16'sd0);
        write_tap(5'd31, -16'sd1);
        write_tap(5'd0, 16'sh4000);
        filter(16'sd1);
        filter(-16'sd1);
        filter(16'sd3);
        filter(-16'sd3);
        filter(16'sh8000);
        filter(16'sh7fff);
        write_tap(5'd31, 16'sd0);
        filter(16'sd0);
        filter(16'sd0);

        // random: rewrite some or all taps, then a run of samples with occasional tap writes
        while (items_sent < RANDOM_ITEMS) begin
            gapless = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
                cmode = $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) begin
                    for (int t = 0; t < TAPS; t++)
                        write_tap(TAP_IDX_BITS'(t), pick_value(cmode));
                end else begin
                    k = $urandom_range(1, 8);
                    repeat (k) write_tap(TAP_IDX_BITS'($urandom), pick_value(cmode));
                end
            end
            smode = $urandom_range(0, 3);
            run   = $urandom_range(10, 60);
            for (int j = 0; j < run; j++) begin
                if ($urandom_range(0, 24) == 0)
                    write_tap(TAP_IDX_BITS'($urandom), pick_value($urandom_range(0, 2)));
                else if (smode == 3)
                    filter(j == 0 ? pick_value(0) : 16'sd0);
                else
                    filter(pick_value(smode));
            end
            if (!drained && items_sent >= DRAIN_AT_ITEM) begin
                drained = 1;
                drain_outputs();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("transposed_fir_filter regression: pass");
        else
            $display("transposed_fir_filter regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tfir_pkg.sv
hdl/tfir_tap.sv
hdl/tfir_round.sv
hdl/transposed_fir_filter.sv
bench/transposed_fir_filter_tb.sv
